// ----- rtl/mtbs_pkg.sv -----
// Shared constants and types of the monotonic table bracket search.
// Used by every module of the block; depends on nothing.
package mtbs_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 7;

    // One bisection cell per halving of the widest search interval.
    localparam int NUM_CELLS = $clog2(TABLE_DEPTH + 1);

    localparam logic [IDX_W-1:0] LEN_RESET = IDX_W'(TABLE_DEPTH);

    // Item operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Which read port holds the entry at a cell's midpoint.
    localparam logic PORT_A = 1'b0;
    localparam logic PORT_B = 1'b1;

    // Search bracket handed from one cell to the next.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic             sel;
    } t_token;

endpackage

// ----- rtl/mtbs_table.sv -----
// Table storage: one write port and two registered read ports.
// Depends on mtbs_pkg.
module mtbs_table import mtbs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [ADDR_W-1:0]        i_raddr_a,
    input  logic [ADDR_W-1:0]        i_raddr_b,
    output logic signed [DATA_W-1:0] o_rdata_a,
    output logic signed [DATA_W-1:0] o_rdata_b
);

    logic signed [DATA_W-1:0] r_mem [TABLE_DEPTH];

    // Entry write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Both reads hold their data while the search is stalled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ----- rtl/mtbs_cell.sv -----
// One bisection step: holds the bracket of the item passing through it and
// prefetches both possible midpoints of the next step. Depends on mtbs_pkg.
module mtbs_cell import mtbs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  t_token                   i_tok,
    input  logic signed [DATA_W-1:0] i_rd_a,
    input  logic signed [DATA_W-1:0] i_rd_b,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic                     i_rising,
    output t_token                   o_tok,
    output logic [ADDR_W-1:0]        o_addr_a,
    output logic [ADDR_W-1:0]        o_addr_b
);

    t_token                   r_tok;
    logic signed [DATA_W-1:0] mid_val;
    logic [IDX_W:0]           sum_mid;
    logic [IDX_W-1:0]         mid;
    logic [IDX_W:0]           sum_up;
    logic [IDX_W:0]           sum_dn;
    logic [IDX_W-1:0]         mid_up;
    logic [IDX_W-1:0]         mid_dn;
    logic                     active;
    logic                     go_up;

    // The bracket moves one cell along whenever the chain advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok.valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok.lo  <= i_tok.lo;
            r_tok.hi  <= i_tok.hi;
            r_tok.sel <= i_tok.sel;
        end
    end

    // Midpoint and the comparison against its entry.
    always_comb begin
        sum_mid = {1'b0, r_tok.hi} + {1'b0, r_tok.lo};
        mid     = sum_mid[IDX_W:1];
        active  = r_tok.hi > (r_tok.lo + IDX_W'(1));
        mid_val = (r_tok.sel == PORT_B) ? i_rd_b : i_rd_a;
        go_up   = (i_x > mid_val) == i_rising;
    end

    // Narrow the bracket; an interval of one is passed on unchanged.
    always_comb begin
        o_tok.valid = r_tok.valid;
        o_tok.lo    = (active && go_up)  ? mid : r_tok.lo;
        o_tok.hi    = (active && !go_up) ? mid : r_tok.hi;
        o_tok.sel   = go_up ? PORT_A : PORT_B;
    end

    // Entries of both candidate next midpoints, 1-based to 0-based.
    always_comb begin
        sum_up   = {1'b0, r_tok.hi} + {1'b0, mid};
        sum_dn   = {1'b0, mid} + {1'b0, r_tok.lo};
        mid_up   = sum_up[IDX_W:1];
        mid_dn   = sum_dn[IDX_W:1];
        o_addr_a = r_tok.valid ? ADDR_W'(mid_up - IDX_W'(1)) : '0;
        o_addr_b = r_tok.valid ? ADDR_W'(mid_dn - IDX_W'(1)) : '0;
    end

endmodule

// ----- rtl/monotonic_table_bracket_search.sv -----
// Top level of the monotonic table bracket search.
// Depends on mtbs_pkg, mtbs_table and mtbs_cell.
//
// A write item stores one table entry and gives no result.
// A query item first passes the setup stages, of which the first reads the
// first and last entries and the other reads the first midpoint and settles
// the search direction; then the item walks through a row of NUM_CELLS
// bisection cells, one cell a cycle while the output does not stall, each
// cell using the two table read ports to fetch both possible midpoints of
// the next step. One query is in the cell row at a time, so a new item is
// taken once the previous query has left the row; a finished result waits
// in the output register without blocking the next item. The table has no
// reset and must be written before it is searched.
module monotonic_table_bracket_search import mtbs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_op,
    input  logic [ADDR_W-1:0]        i_entry_index,
    input  logic signed [DATA_W-1:0] i_sample_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [IDX_W-1:0]         o_bracket_index,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [IDX_W-1:0]         i_cfg_table_length
);

    logic [IDX_W-1:0]         r_len;
    logic                     r_s1;
    logic                     r_s2;
    logic signed [DATA_W-1:0] r_x;
    logic [IDX_W-1:0]         r_n;
    logic signed [DATA_W-1:0] r_first;
    logic signed [DATA_W-1:0] r_last;
    logic                     r_rising;
    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_bracket;
    logic [IDX_W-1:0]         n_len_eff;
    logic [IDX_W-1:0]         n_result;
    logic [IDX_W:0]           mid0_sum;
    logic                     in_acc;
    logic                     busy;
    logic                     stall;
    logic                     adv;
    logic                     wr_en;
    logic [ADDR_W-1:0]        raddr_a;
    logic [ADDR_W-1:0]        raddr_b;
    logic signed [DATA_W-1:0] rdata_a;
    logic signed [DATA_W-1:0] rdata_b;
    t_token                   tok [NUM_CELLS+1];
    logic [ADDR_W-1:0]        cell_addr_a [NUM_CELLS];
    logic [ADDR_W-1:0]        cell_addr_b [NUM_CELLS];
    logic [NUM_CELLS-1:0]     cell_busy;

    // Handshakes: a new item only once the setup stages and the cell row are empty.
    always_comb begin
        for (int k = 0; k < NUM_CELLS; k++) begin
            cell_busy[k] = tok[k+1].valid;
        end
        busy  = r_s1 || r_s2 || (|cell_busy);
        stall = tok[NUM_CELLS].valid && r_out_valid && !i_out_ready;
        adv   = !stall;
    end

    assign o_in_ready  = !busy;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign wr_en       = in_acc && (i_op == OP_WRITE)
                         && ({1'b0, i_entry_index} < (ADDR_W + 1)'(TABLE_DEPTH));

    // Length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_len <= i_cfg_table_length;
        end
    end

    // Length in use, held to the range one to the table depth.
    always_comb begin
        if (r_len == '0) begin
            n_len_eff = IDX_W'(1);
        end else if (r_len > IDX_W'(TABLE_DEPTH)) begin
            n_len_eff = IDX_W'(TABLE_DEPTH);
        end else begin
            n_len_eff = r_len;
        end
    end

    // Setup stages: read the end entries, then the first midpoint.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= 1'b0;
            r_s2 <= 1'b0;
        end else begin
            r_s1 <= in_acc && (i_op == OP_QUERY);
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_op == OP_QUERY)) begin
            r_x <= i_sample_value;
            r_n <= n_len_eff;
        end
        if (r_s2) begin
            r_first  <= rdata_a;
            r_last   <= rdata_b;
            r_rising <= rdata_b > rdata_a;
        end
    end

    assign mid0_sum = {1'b0, r_n} + (IDX_W + 1)'(1);

    // The first cell starts from the full bracket.
    always_comb begin
        tok[0].valid = r_s2;
        tok[0].lo    = '0;
        tok[0].hi    = r_n + IDX_W'(1);
        tok[0].sel   = PORT_A;
    end

    // Read addresses come from whichever stage holds the item.
    always_comb begin
        raddr_a = '0;
        raddr_b = '0;
        if (r_s1) begin
            raddr_b = ADDR_W'(r_n - IDX_W'(1));
        end
        if (r_s2) begin
            raddr_a = ADDR_W'(mid0_sum[IDX_W:1] - IDX_W'(1));
        end
        for (int k = 0; k < NUM_CELLS; k++) begin
            raddr_a = raddr_a | cell_addr_a[k];
            raddr_b = raddr_b | cell_addr_b[k];
        end
    end

    mtbs_table u_table (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (i_entry_index),
        .i_wdata   (i_sample_value),
        .i_re      (adv),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Row of bisection cells.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        mtbs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_tok    (tok[g]),
            .i_rd_a   (rdata_a),
            .i_rd_b   (rdata_b),
            .i_x      (r_x),
            .i_rising (r_rising),
            .o_tok    (tok[g+1]),
            .o_addr_a (cell_addr_a[g]),
            .o_addr_b (cell_addr_b[g])
        );
    end

    // Exact hits on the end entries override the bisection.
    always_comb begin
        if (r_x == r_first) begin
            n_result = IDX_W'(1);
        end else if (r_x == r_last) begin
            n_result = r_n - IDX_W'(1);
        end else begin
            n_result = tok[NUM_CELLS].lo;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= tok[NUM_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out_bracket <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bracket_index = r_out_bracket;

endmodule

// ----- rtl/mtbs_checker.sv -----
// Port-level checks of the bracket search, bound to the top level.
// Depends on mtbs_pkg and monotonic_table_bracket_search.
module mtbs_checker import mtbs_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             i_op,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [IDX_W-1:0] o_bracket_index
);

    // A query occupies the search, so the next item must wait.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_op == OP_QUERY)) |=> !o_in_ready)
        else $error("input still ready right after a query item");

    // A write item finishes at once.
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_op == OP_WRITE)) |=> o_in_ready)
        else $error("input not ready after a write item");

    // A bracket never exceeds the table depth.
    a_bracket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bracket_index <= IDX_W'(TABLE_DEPTH)))
        else $error("bracket index beyond table depth");

    // A result that is not taken holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_bracket_index)))
        else $error("result changed while stalled");

endmodule

bind monotonic_table_bracket_search mtbs_checker u_mtbs_checker (.*);

// ----- sim/monotonic_table_bracket_search_tb.sv -----
// Self-checking testbench for the monotonic table bracket search.
// Depends on mtbs_pkg and monotonic_table_bracket_search; checks every bracket
// against a local bisection predictor while both sides idle at random outside a calm window.
module monotonic_table_bracket_search_tb import mtbs_pkg::*;;

    localparam int     SETTLE_CYCLES = 16;
    localparam int     CYCLE_LIMIT   = 300000;
    localparam int     STALL_PCT     = 30;
    localparam int     ITEM_TARGET   = 430;
    localparam longint Q_MIN         = -(64'sd1 <<< 31);
    localparam longint Q_MAX         = (64'sd1 <<< 31) - 1;

    typedef struct {
        logic                     op;
        logic [ADDR_W-1:0]        idx;
        logic signed [DATA_W-1:0] val;
    } t_item;

    // Clock, reset and block inputs, all known from time zero.
    logic                     i_clk          = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     in_valid       = 1'b0;
    logic                     in_op          = OP_WRITE;
    logic [ADDR_W-1:0]        in_entry_index = '0;
    logic signed [DATA_W-1:0] in_sample_value = '0;
    logic                     out_ready      = 1'b0;
    logic                     cfg_valid      = 1'b0;
    logic [IDX_W-1:0]         cfg_length     = LEN_RESET;

    logic                     o_in_ready;
    logic                     o_out_valid;
    logic [IDX_W-1:0]         o_bracket_index;
    logic                     o_cfg_ready;

    // Predictor state, updated when items and register writes are accepted.
    logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
    logic [IDX_W-1:0]         shadow_length = LEN_RESET;

    // Generator view of the table, used only to pick meaningful queries.
    logic signed [DATA_W-1:0] gen_table [TABLE_DEPTH];
    int                       gen_items = 0;

    t_item                    pending_items[$];
    logic [IDX_W-1:0]         expected_brackets[$];
    t_item                    next_item;
    logic [IDX_W-1:0]         want_bracket;
    int                       sent_count     = 0;
    int                       mismatch_count = 0;
    int                       cycle_count    = 0;
    logic                     calm;

    // A window of items during which neither side stalls.
    assign calm = (sent_count >= 150) && (sent_count < 260);

    monotonic_table_bracket_search dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (in_op),
        .i_entry_index      (in_entry_index),
        .i_sample_value     (in_sample_value),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_bracket_index    (o_bracket_index),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_table_length (cfg_length)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Bisection over the shadow table; the equality checks come after the walk.
    function automatic logic [IDX_W-1:0] locate_bracket(input logic signed [DATA_W-1:0] x);
        int                       n;
        int                       lo;
        int                       hi;
        int                       mid;
        logic signed [DATA_W-1:0] first;
        logic signed [DATA_W-1:0] last;
        logic                     rising;
        logic                     above;
        n = int'(shadow_length);
        if (n < 1) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        lo = 0;
        hi = n + 1;
        first = shadow_table[0];
        last = shadow_table[n-1];
        // Equal end points select the decreasing direction.
        rising = last > first;
        while (hi - lo > 1) begin
            mid = (hi + lo) >> 1;
            above = x > shadow_table[mid-1];
            if (above == rising) lo = mid;
            else hi = mid;
        end
        if (x == first) return IDX_W'(1);
        if (x == last) return IDX_W'(n - 1);
        return IDX_W'(lo);
    endfunction

    task automatic push_item(input logic op, input logic [ADDR_W-1:0] idx,
                             input logic signed [DATA_W-1:0] val);
        t_item it;
        it.op = op;
        it.idx = idx;
        it.val = val;
        pending_items.push_back(it);
        if (op == OP_WRITE) gen_table[idx] = val;
        gen_items++;
    endtask

    // Waits until every item is sent and answered, then lets a write drain.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_items.size() != 0 || in_valid || expected_brackets.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_length(input logic [IDX_W-1:0] len);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_length = len;
        cfg_valid <= 1'b0;
    endtask

    // Input driver: sends queued items, stalling at random outside the calm window.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                sent_count <= sent_count + 1;
                if (in_op == OP_WRITE) shadow_table[in_entry_index] = in_sample_value;
                else expected_brackets.push_back(locate_bracket(in_sample_value));
            end
            if (!in_valid || o_in_ready) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    in_op <= next_item.op;
                    in_entry_index <= next_item.idx;
                    in_sample_value <= next_item.val;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted bracket with the oldest prediction.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_brackets.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: bracket_index=%0d", o_bracket_index);
                end else begin
                    want_bracket = expected_brackets.pop_front();
                    if (o_bracket_index !== want_bracket) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("bracket_index mismatch: expected %0d, actual %0d",
                                     want_bracket, o_bracket_index);
                    end
                end
            end
            out_ready <= calm || ($urandom_range(99) >= STALL_PCT);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("monotonic_table_bracket_search_tb: errors");
            $finish;
        end
    end

    // Stimulus: a directed part on tiny tables, then random phases.
    initial begin
        int                       n;
        int                       mode;
        int                       scale;
        int                       k;
        int                       nq;
        int                       r;
        int                       phase;
        longint                   acc;
        longint                   step_max;
        logic signed [DATA_W-1:0] qv;
        logic [IDX_W-1:0]         len;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // Single-entry table, including the top write address.
        write_length(IDX_W'(1));
        push_item(OP_WRITE, ADDR_W'(0), 32'sh0005_0000);
        push_item(OP_WRITE, ADDR_W'(63), 32'sh8000_0000);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0005_0000);
        push_item(OP_QUERY, ADDR_W'(63), 32'sh7FFF_FFFF);
        push_item(OP_QUERY, ADDR_W'(21), 32'sh8000_0000);
        wait_idle();

        // A zero length behaves as a single entry.
        write_length(IDX_W'(0));
        push_item(OP_QUERY, ADDR_W'(42), 32'sh0005_0000);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0000_0000);
        wait_idle();

        // Equal first and last entries, which is also non-monotonic.
        write_length(IDX_W'(3));
        push_item(OP_WRITE, ADDR_W'(0), 32'sh0000_0007);
        push_item(OP_WRITE, ADDR_W'(1), 32'sh0000_0009);
        push_item(OP_WRITE, ADDR_W'(2), 32'sh0000_0007);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0000_0007);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0000_0008);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0000_0009);
        wait_idle();

        // Decreasing three-entry table: inside, on the ends and outside.
        push_item(OP_WRITE, ADDR_W'(0), 32'sh0000_012C);
        push_item(OP_WRITE, ADDR_W'(1), 32'sh0000_00C8);
        push_item(OP_WRITE, ADDR_W'(2), 32'sh0000_0064);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0000_00FA);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0000_0064);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0000_012C);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0000_0032);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0000_0190);
        wait_idle();

        // Two entries spanning the whole value range.
        write_length(IDX_W'(2));
        push_item(OP_WRITE, ADDR_W'(0), 32'sh8000_0000);
        push_item(OP_WRITE, ADDR_W'(1), 32'sh7FFF_FFFF);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh8000_0000);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh7FFF_FFFF);
        push_item(OP_QUERY, ADDR_W'(0), 32'sh0000_0000);

        // Random phases; the first one fills the whole table.
        phase = 0;
        while (gen_items < ITEM_TARGET) begin
            if (phase == 0) begin
                len = IDX_W'(TABLE_DEPTH);
            end else begin
                case ($urandom_range(9))
                    0: len = IDX_W'(TABLE_DEPTH);
                    1: len = IDX_W'(1);
                    2: len = IDX_W'(127);
                    3: len = IDX_W'(0);
                    4: len = IDX_W'(2);
                    default: len = IDX_W'($urandom_range(3, 40));
                endcase
            end
            wait_idle();
            write_length(len);
            n = int'(len);
            if (n < 1) n = 1;
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;

            // Mostly increasing or decreasing tables, some pure noise.
            mode = $urandom_range(9);
            scale = $urandom_range(2);
            step_max = (scale == 0) ? 3 : (scale == 1) ? 65536 : (64'sd1 <<< 25);
            acc = longint'($signed($urandom));
            if (scale == 2) begin
                if (mode < 4) acc = Q_MIN + $urandom_range(0, 1 << 30);
                else acc = Q_MAX - $urandom_range(0, 1 << 30);
            end
            for (k = 0; k < n; k++) begin
                if (acc > Q_MAX) acc = Q_MAX;
                if (acc < Q_MIN) acc = Q_MIN;
                push_item(OP_WRITE, ADDR_W'(k), acc[DATA_W-1:0]);
                if (mode < 4) acc = acc + $urandom_range(0, int'(step_max));
                else if (mode < 8) acc = acc - $urandom_range(0, int'(step_max));
                else acc = longint'($signed($urandom));
            end

            // Queries near the entries, with a few stray writes mixed in.
            nq = $urandom_range(8, 24);
            for (int q = 0; q < nq; q++) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    push_item(OP_WRITE, ADDR_W'($urandom_range(63)), $urandom);
                end else begin
                    k = $urandom_range(n - 1);
                    case ($urandom_range(9))
                        0, 1, 2, 3: qv = gen_table[k];
                        4: qv = gen_table[k] + 1;
                        5: qv = gen_table[k] - 1;
                        6: begin
                            if (n > 1) begin
                                k = $urandom_range(n - 2);
                                acc = (longint'(gen_table[k]) + longint'(gen_table[k+1])) >>> 1;
                                qv = acc[DATA_W-1:0];
                            end else begin
                                qv = gen_table[0];
                            end
                        end
                        7: qv = $urandom;
                        8: qv = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                        default: begin
                            acc = longint'($urandom_range(1) ? gen_table[0] : gen_table[n-1]);
                            acc = acc + longint'($signed(DATA_W'($urandom_range(0, 64)))) - 32;
                            if (acc > Q_MAX) acc = Q_MAX;
                            if (acc < Q_MIN) acc = Q_MIN;
                            qv = acc[DATA_W-1:0];
                        end
                    endcase
                    push_item(OP_QUERY, ADDR_W'($urandom_range(63)), qv);
                end
            end
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("monotonic_table_bracket_search_tb: clean");
        end else begin
            $display("monotonic_table_bracket_search_tb: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mtbs_pkg.sv
rtl/mtbs_table.sv
rtl/mtbs_cell.sv
rtl/monotonic_table_bracket_search.sv
rtl/mtbs_checker.sv
sim/monotonic_table_bracket_search_tb.sv
